/* design/per_bin_frame_moving_average_assert.svh */
// Assertion macros used by the checker file of the per-bin moving average.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PER_BIN_FRAME_MOVING_AVERAGE_ASSERT_SVH
`define PER_BIN_FRAME_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PBFMA_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pbfma: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PBFMA_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pbfma: next-cycle check failed");

`endif

/* design/pbfma_pkg.sv */
// Package for the per-bin moving average: command and register codes,
// configuration constants and the controller/datapath structs. No dependencies.
`default_nettype none

package pbfma_pkg;

    // Request commands.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DEPTH_W    = 7;
    localparam int RANGE_W    = 11;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd64;
    localparam logic [RANGE_W-1:0] START_RESET = 11'd0;
    localparam logic [RANGE_W-1:0] END_RESET   = 11'd1024;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // latch the accepted request
        logic rd_bin;    // read memories for the current bin
        logic rd_rm;     // read sum and newest frame entry at the sweep bin
        logic wr_push;   // update the current bin with the sample
        logic wr_close;  // update the current bin with zero
        logic div_wr;    // store the finished average
        logic close_end; // frame bookkeeping after the last bin
        logic rm_wr;     // subtract the newest frame at the sweep bin
        logic rm_end;    // drop the newest frame from the count
        logic clr_wr;    // zero one bin and the counters
        logic put;       // move the result into the output register
    } pbfma_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       last;
        logic       bc_zero;
        logic       bc_in_range;
        logic       cnt_nz;
        logic       swp_final;
        logic       div_pend;
        logic       div_busy;
        logic       out_free;
    } pbfma_sts_t;

endpackage

`default_nettype wire

/* design/pbfma_if.sv */
// Channel interfaces of the per-bin moving average: sample requests, results
// and configuration writes. Depends on pbfma_pkg for the configuration widths.
`default_nettype none

interface pbfma_smp_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_frame;

    modport source (output valid, cmd, sample, last_in_frame, input ready);
    modport sink (input valid, cmd, sample, last_in_frame, output ready);
endinterface

interface pbfma_res_if #(parameter int BIN_W = 10, parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic [BIN_W-1:0]              bin_index;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          frame_done;

    modport source (output valid, bin_index, average, frame_done, input ready);
    modport sink (input valid, bin_index, average, frame_done, output ready);
endinterface

interface pbfma_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pbfma_pkg::CFG_IDX_W-1:0]  index;
    logic [pbfma_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/pbfma_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone; used by pbfma_dp for the per-bin average.
`default_nettype none

module pbfma_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic signed [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // Restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, q_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            q_next    = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[NUM_W-1];
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

`default_nettype wire

/* design/pbfma_dp.sv */
// Datapath of the per-bin moving average: frame ring, sum and average memories,
// counters, configuration and output registers. Uses pbfma_pkg and pbfma_div.
`default_nettype none

module pbfma_dp #(
    parameter int BINS        = 1024,
    parameter int MAX_FRAMES  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int BIN_W       = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pbfma_pkg::pbfma_ctl_t                ctl,
    output pbfma_pkg::pbfma_sts_t                sts,
    input  logic [1:0]                           in_cmd,
    input  logic signed [SAMPLE_BITS-1:0]        in_sample,
    input  logic                                 in_last,
    input  logic                                 cfg_valid,
    input  logic [pbfma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pbfma_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [BIN_W-1:0]                     out_bin_index,
    output logic signed [SAMPLE_BITS-1:0]        out_average,
    output logic                                 out_frame_done
);
    import pbfma_pkg::*;

    localparam int BC_W     = $clog2(BINS + 1);
    localparam int SLOT_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_FRAMES);
    localparam int ST_DEPTH = MAX_FRAMES * (1 << BIN_W);
    localparam int CMP_W    = (BC_W > RANGE_W) ? BC_W : RANGE_W;
    localparam int SL2_W    = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam logic signed [SUM_W-1:0] AVG_HI = SUM_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] AVG_LO = -AVG_HI - SUM_W'(1);

    // Configuration registers.
    logic [DEPTH_W-1:0] depth_reg;
    logic [RANGE_W-1:0] start_reg;
    logic [RANGE_W-1:0] end_reg;

    // Latched request and running state.
    logic [1:0]                    cmd_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [SLOT_W-1:0]             oldest_reg;
    logic [BC_W-1:0]               bc_reg;
    logic                          evict_reg;
    logic [BIN_W-1:0]              swp_reg;
    logic                          div_pend_reg;

    // Pending result and output register.
    logic [BIN_W-1:0]              res_idx_reg;
    logic signed [SAMPLE_BITS-1:0] res_avg_reg;
    logic                          res_done_reg;
    logic                          out_valid_reg;
    logic [BIN_W-1:0]              out_idx_reg;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg;
    logic                          out_done_reg;

    // Memories and their registered read data.
    logic signed [SAMPLE_BITS-1:0] store_mem [ST_DEPTH];
    logic signed [SUM_W-1:0]       sum_mem [BINS];
    logic signed [SAMPLE_BITS-1:0] avg_mem [BINS];
    logic signed [SAMPLE_BITS-1:0] st_rd_reg;
    logic signed [SUM_W-1:0]       sum_rd_reg;
    logic signed [SAMPLE_BITS-1:0] avg_rd_reg;

    logic [BIN_W-1:0]              bin;
    logic [SL2_W-1:0]              slot_sum;
    logic [SL2_W-1:0]              slot_dec;
    logic [SLOT_W-1:0]             slot_new;
    logic [SLOT_W-1:0]             slot_newest;
    logic [SLOT_W-1:0]             oldest_inc;
    logic [CNT_W-1:0]              depth_eff;
    logic                          inr;
    logic signed [SAMPLE_BITS-1:0] s_val;
    logic signed [SUM_W-1:0]       sum_new;
    logic signed [SUM_W-1:0]       sum_rm;
    logic [CNT_W-1:0]              den;
    logic                          div_start;
    logic                          div_busy;
    logic signed [SUM_W-1:0]       quo;
    logic signed [SAMPLE_BITS-1:0] avg_sat;
    logic [SLOT_W+BIN_W-1:0]       st_rd_addr;
    logic [SLOT_W+BIN_W-1:0]       st_wr_addr;
    logic [BIN_W-1:0]              sum_rd_addr;
    logic [BIN_W-1:0]              sum_wr_addr;
    logic signed [SUM_W-1:0]       sum_wr_data;
    logic                          sum_we;
    logic                          req_done;

    // Ring slots: the slot written by the open frame and the newest stored one.
    always_comb
    begin
        bin         = bc_reg[BIN_W-1:0];
        slot_sum    = SL2_W'(oldest_reg) + SL2_W'(cnt_reg);
        slot_new    = (slot_sum >= SL2_W'(MAX_FRAMES)) ?
                      SLOT_W'(slot_sum - SL2_W'(MAX_FRAMES)) : SLOT_W'(slot_sum);
        slot_dec    = slot_sum - SL2_W'(1);
        slot_newest = (slot_dec >= SL2_W'(MAX_FRAMES)) ?
                      SLOT_W'(slot_dec - SL2_W'(MAX_FRAMES)) : SLOT_W'(slot_dec);
        oldest_inc  = (oldest_reg == SLOT_W'(MAX_FRAMES - 1)) ? '0 : oldest_reg + 1'b1;
        depth_eff   = (depth_reg == '0 || int'(depth_reg) > MAX_FRAMES) ?
                      CNT_W'(MAX_FRAMES) : CNT_W'(depth_reg);
    end

    // Bin update: subtract the evicted entry, add the new one.
    always_comb
    begin
        inr       = (CMP_W'(bc_reg) >= CMP_W'(start_reg)) && (CMP_W'(bc_reg) < CMP_W'(end_reg));
        s_val     = (ctl.wr_push && inr) ? samp_reg : '0;
        sum_new   = sum_rd_reg - (evict_reg ? SUM_W'(st_rd_reg) : SUM_W'(0)) + SUM_W'(s_val);
        sum_rm    = sum_rd_reg - SUM_W'(st_rd_reg);
        den       = evict_reg ? cnt_reg : cnt_reg + 1'b1;
        div_start = ctl.wr_push && inr;
        if (quo > AVG_HI)
        begin
            avg_sat = SAMPLE_BITS'(AVG_HI);
        end
        else if (quo < AVG_LO)
        begin
            avg_sat = SAMPLE_BITS'(AVG_LO);
        end
        else
        begin
            avg_sat = SAMPLE_BITS'(quo);
        end
    end

    pbfma_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_new),
        .den   (den),
        .busy  (div_busy),
        .quo   (quo)
    );

    // Memory address and write data selection.
    always_comb
    begin
        st_rd_addr  = ctl.rd_rm ? {slot_newest, swp_reg} : {oldest_reg, bin};
        st_wr_addr  = {slot_new, bin};
        sum_rd_addr = ctl.rd_rm ? swp_reg : bin;
        sum_we      = ctl.clr_wr || ctl.wr_push || ctl.wr_close || ctl.rm_wr;
        sum_wr_addr = (ctl.clr_wr || ctl.rm_wr) ? swp_reg : bin;
        if (ctl.clr_wr)
        begin
            sum_wr_data = '0;
        end
        else if (ctl.rm_wr)
        begin
            sum_wr_data = sum_rm;
        end
        else
        begin
            sum_wr_data = sum_new;
        end
    end

    // Frame ring memory.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_push || ctl.wr_close)
        begin
            store_mem[st_wr_addr] <= s_val;
        end
        if (ctl.rd_bin || ctl.rd_rm)
        begin
            st_rd_reg <= store_mem[st_rd_addr];
        end
    end

    // Running sum memory.
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wr_addr] <= sum_wr_data;
        end
        if (ctl.rd_bin || ctl.rd_rm)
        begin
            sum_rd_reg <= sum_mem[sum_rd_addr];
        end
    end

    // Average memory; a finished average goes to the bin of the pending result.
    always_ff @(posedge clk)
    begin
        if (ctl.clr_wr)
        begin
            avg_mem[swp_reg] <= '0;
        end
        else if (ctl.div_wr)
        begin
            avg_mem[res_idx_reg] <= avg_sat;
        end
        if (ctl.rd_bin)
        begin
            avg_rd_reg <= avg_mem[bin];
        end
    end

    assign req_done = (in_cmd == CMD_PUSH && in_last) || in_cmd == CMD_REMOVE ||
                      in_cmd == CMD_CLEAR;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
            start_reg <= START_RESET;
            end_reg   <= END_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEPTH: depth_reg <= cfg_data[DEPTH_W-1:0];
                REG_START: start_reg <= cfg_data[RANGE_W-1:0];
                REG_END:   end_reg   <= cfg_data[RANGE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Frame counters, sweep pointer and pending result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_PUSH;
            last_reg     <= 1'b0;
            cnt_reg      <= '0;
            oldest_reg   <= '0;
            bc_reg       <= '0;
            evict_reg    <= 1'b0;
            swp_reg      <= '0;
            div_pend_reg <= 1'b0;
            res_idx_reg  <= '0;
            res_avg_reg  <= '0;
            res_done_reg <= 1'b0;
        end
        else
        begin
            if (ctl.take)
            begin
                cmd_reg      <= in_cmd;
                last_reg     <= in_last;
                res_idx_reg  <= '0;
                res_avg_reg  <= '0;
                res_done_reg <= req_done;
                if (in_cmd == CMD_PUSH && bc_reg == '0)
                begin
                    evict_reg <= (cnt_reg >= depth_eff);
                end
            end
            if (ctl.wr_push)
            begin
                bc_reg       <= bc_reg + 1'b1;
                res_idx_reg  <= bin;
                res_avg_reg  <= avg_rd_reg;
                div_pend_reg <= inr;
            end
            if (ctl.wr_close)
            begin
                bc_reg <= bc_reg + 1'b1;
            end
            if (ctl.div_wr)
            begin
                res_avg_reg  <= avg_sat;
                div_pend_reg <= 1'b0;
            end
            if (ctl.close_end)
            begin
                if (evict_reg)
                begin
                    oldest_reg <= oldest_inc;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                bc_reg    <= '0;
                evict_reg <= 1'b0;
            end
            if (ctl.rm_wr || ctl.clr_wr)
            begin
                swp_reg <= (swp_reg == BIN_W'(BINS - 1)) ? '0 : swp_reg + 1'b1;
            end
            if (ctl.rm_end)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (ctl.clr_wr)
            begin
                cnt_reg    <= '0;
                oldest_reg <= '0;
                bc_reg     <= '0;
                evict_reg  <= 1'b0;
            end
        end
    end

    // Output register, loaded while the previous result is taken or gone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            samp_reg <= in_sample;
        end
        if (ctl.put)
        begin
            out_idx_reg  <= res_idx_reg;
            out_avg_reg  <= res_avg_reg;
            out_done_reg <= res_done_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.cmd         = cmd_reg;
        sts.last        = last_reg;
        sts.bc_zero     = (bc_reg == '0);
        sts.bc_in_range = (bc_reg < BC_W'(BINS));
        sts.cnt_nz      = (cnt_reg != '0);
        sts.swp_final   = (swp_reg == BIN_W'(BINS - 1));
        sts.div_pend    = div_pend_reg;
        sts.div_busy    = div_busy;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_bin_index  = out_idx_reg;
    assign out_average    = out_avg_reg;
    assign out_frame_done = out_done_reg;

endmodule

`default_nettype wire

/* design/pbfma_ctrl.sv */
// Controller of the per-bin moving average: sequences reads, writes, the
// divider and the clearing, closing and removal sweeps. Uses pbfma_pkg.
`default_nettype none

module pbfma_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pbfma_pkg::pbfma_sts_t sts,
    output pbfma_pkg::pbfma_ctl_t ctl
);
    import pbfma_pkg::*;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_PRD  = 4'd3;
    localparam logic [3:0] S_PWR  = 4'd4;
    localparam logic [3:0] S_DIVW = 4'd5;
    localparam logic [3:0] S_CLS  = 4'd6;
    localparam logic [3:0] S_CRD  = 4'd7;
    localparam logic [3:0] S_CWR  = 4'd8;
    localparam logic [3:0] S_CEND = 4'd9;
    localparam logic [3:0] S_RMC  = 4'd10;
    localparam logic [3:0] S_RRD  = 4'd11;
    localparam logic [3:0] S_RWR  = 4'd12;
    localparam logic [3:0] S_CLR  = 4'd13;
    localparam logic [3:0] S_PUT  = 4'd14;

    logic [3:0] state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.swp_final)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.cmd)
                    CMD_PUSH:
                    begin
                        if (sts.bc_in_range)
                        begin
                            state_next = S_PRD;
                        end
                        else
                        begin
                            state_next = sts.last ? S_CLS : S_PUT;
                        end
                    end
                    CMD_REMOVE: state_next = sts.bc_zero ? S_RMC : S_CLS;
                    CMD_CLEAR:  state_next = S_CLR;
                    default:    state_next = S_PUT;
                endcase
            end
            S_PRD:
            begin
                ctl.rd_bin = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                ctl.wr_push = 1'b1;
                state_next  = S_DIVW;
            end
            S_DIVW:
            begin
                if (!sts.div_pend || !sts.div_busy)
                begin
                    ctl.div_wr = sts.div_pend;
                    state_next = sts.last ? S_CLS : S_PUT;
                end
            end
            S_CLS:
            begin
                state_next = sts.bc_in_range ? S_CRD : S_CEND;
            end
            S_CRD:
            begin
                ctl.rd_bin = 1'b1;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                ctl.wr_close = 1'b1;
                state_next   = S_CLS;
            end
            S_CEND:
            begin
                ctl.close_end = 1'b1;
                state_next    = (sts.cmd == CMD_REMOVE) ? S_RMC : S_PUT;
            end
            S_RMC:
            begin
                state_next = sts.cnt_nz ? S_RRD : S_PUT;
            end
            S_RRD:
            begin
                ctl.rd_rm  = 1'b1;
                state_next = S_RWR;
            end
            S_RWR:
            begin
                ctl.rm_wr = 1'b1;
                if (sts.swp_final)
                begin
                    ctl.rm_end = 1'b1;
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_RRD;
                end
            end
            S_CLR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.swp_final)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (sts.out_free)
                begin
                    ctl.put    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/per_bin_frame_moving_average.sv */
// Top level of the per-bin moving average over the most recent frames.
// Depends on pbfma_pkg, pbfma_if, pbfma_ctrl, pbfma_dp and pbfma_div.
//
//   Channel   Direction  Contents
//   samples   in         cmd, sample, last_in_frame
//   results   out        bin_index, average, frame_done
//   cfg       in         index, data (cache_depth, start_bin, end_bin)
//
// One request at a time. A sample in range reads its bin, writes it and then waits
// for the bit-serial divider; a sample outside the range does not wait for it.
// Closing a frame reads and writes each bin not yet written, remove sweeps every
// bin with a read and a write, and clear zeroes every bin in a memory sweep.
// After reset a clearing pass over all BINS bins runs before the first request.
// A result waits in the output register without blocking the next request.
`default_nettype none

module per_bin_frame_moving_average #(
    parameter int BINS        = 1024,
    parameter int MAX_FRAMES  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    pbfma_smp_if.sink  samples,
    pbfma_res_if.source results,
    pbfma_cfg_if.sink  cfg
);
    import pbfma_pkg::*;

    localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;

    pbfma_ctl_t ctl;
    pbfma_sts_t sts;

    // Controller.
    pbfma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Datapath.
    pbfma_dp #(
        .BINS        (BINS),
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .BIN_W       (BIN_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .in_cmd         (samples.cmd),
        .in_sample      (samples.sample),
        .in_last        (samples.last_in_frame),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .out_bin_index  (results.bin_index),
        .out_average    (results.average),
        .out_frame_done (results.frame_done)
    );

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

endmodule

`default_nettype wire

/* design/pbfma_check.sv */
// Port-level checks for the per-bin moving average, bound to the top level.
// Depends on per_bin_frame_moving_average_assert.svh.
`default_nettype none
`include "per_bin_frame_moving_average_assert.svh"

module pbfma_check #(
    parameter int BIN_W       = 10,
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   r_valid,
    input logic                   r_ready,
    input logic [BIN_W-1:0]       r_bin_index,
    input logic [SAMPLE_BITS-1:0] r_average,
    input logic                   r_frame_done
);

    // A stalled result holds its payload.
    `PBFMA_ASSERT_NEXT(a_res_hold, r_valid && !r_ready, r_valid && $stable(r_bin_index) && $stable(r_average) && $stable(r_frame_done))

    // Only one request is in work at a time.
    `PBFMA_ASSERT_NEXT(a_one_request, s_valid && s_ready, !s_ready)

    // A new result is loaded only while no request is taken.
    `PBFMA_ASSERT_IMP(a_load_gap, $rose(r_valid), $past(!s_ready))

endmodule

bind per_bin_frame_moving_average pbfma_check #(
    .BIN_W       (BIN_W),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pbfma_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_valid      (samples.valid),
    .s_ready      (samples.ready),
    .r_valid      (results.valid),
    .r_ready      (results.ready),
    .r_bin_index  (results.bin_index),
    .r_average    (results.average),
    .r_frame_done (results.frame_done)
);

`default_nettype wire
